// ----- src/oledfb_pkg.sv -----
package oledfb_pkg;

  localparam int DISPLAY_WIDTH_DEF = 128;
  localparam int DISPLAY_PAGES_DEF = 8;

  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_CHAR    = 2'd1;
  localparam logic [1:0] KIND_REFRESH = 2'd2;

  localparam logic [7:0] CMD_CTRL      = 8'h00;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] DATA_CTRL     = 8'h40;

  localparam logic [7:0] CHAR_NUL = 8'h00;

  // glyph columns, leftmost column in the top byte
  localparam logic [39:0] GLYPH_LETTERS [26] = '{
    40'h7C_12_11_12_7C, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22, 40'h7F_41_41_22_1C,
    40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F,
    40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
    40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E, 40'h7F_09_09_09_06,
    40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31, 40'h01_01_7F_01_01,
    40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F, 40'h63_14_08_14_63,
    40'h07_08_70_08_07, 40'h61_51_49_45_43
  };

  localparam logic [39:0] GLYPH_NUMERALS [10] = '{
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E
  };

  localparam logic [39:0] GLYPH_COLON   = 40'h00_36_36_00_00;
  localparam logic [39:0] GLYPH_EXCLAIM = 40'h00_08_3E_08_00;
  localparam logic [39:0] GLYPH_PERCENT = 40'h00_64_18_64_00;
  localparam logic [39:0] GLYPH_PERIOD  = 40'h00_40_60_00_00;

  function automatic logic [39:0] glyph_bits(input logic [7:0] ch);
    logic [39:0] g;
    g = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      g = GLYPH_LETTERS[5'(ch - 8'h41)];
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      g = GLYPH_NUMERALS[4'(ch - 8'h30)];
    end else begin
      unique case (ch)
        8'h3A:   g = GLYPH_COLON;
        8'h21:   g = GLYPH_EXCLAIM;
        8'h25:   g = GLYPH_PERCENT;
        8'h2E:   g = GLYPH_PERIOD;
        default: g = '0;
      endcase
    end
    return g;
  endfunction

endpackage

// ----- src/oled_text_framebuffer.sv -----
// Steps: a refresh byte is accepted with the store read, its byte selected, then the result;
// a drawn character is accepted, takes six store writes, then the result; other characters and
// kind 3 go straight to the result; a clear sweeps the whole store first. A stalled result adds its wait.
// Throughput: one item at a time, the next is taken once the result is registered; a character
// is bound by its six writes to the single store write port, a clear by its full sweep.
// Reset: synchronous, active low; after release a clearing sweep over all
// DISPLAY_WIDTH*DISPLAY_PAGES store addresses zeroes the store while in_tready stays low.
module oled_text_framebuffer #(
  parameter int DISPLAY_WIDTH = oledfb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_PAGES = oledfb_pkg::DISPLAY_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // column[7:0], page[15:8], character[23:16]
  input  logic [2:0]  in_tuser,   // kind[1:0], text_start[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_valid[0], out_byte[8:1], zero fill[15:9]
  output logic [2:0]  out_tuser,  // transaction_start[0], frame_done[1], char_drawn[2]
  output logic        out_tlast   // transaction_end
);

  import oledfb_pkg::*;

  localparam int STORE_SIZE = DISPLAY_WIDTH * DISPLAY_PAGES;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int CCW        = $clog2(DISPLAY_WIDTH + 1);
  localparam int PW         = (DISPLAY_PAGES > 1) ? $clog2(DISPLAY_PAGES) : 1;
  localparam int POSW       = $clog2(DISPLAY_WIDTH + 5);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DRAW,
    ST_FETCH,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       tstart;
    logic       tend;
    logic       done;
    logic       drawn;
  } res_t;

  localparam res_t RES_DRAWN = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};

  state_t          state_r;
  logic [AW-1:0]   clr_addr_r;
  logic            sweep_reply_r;
  logic [CCW-1:0]  cursor_col_r;
  logic [PW-1:0]   cursor_page_r;
  logic            active_r;
  logic [PW-1:0]   ref_page_r;
  logic [POSW-1:0] ref_pos_r;
  logic [AW-1:0]   wr_addr_r;
  logic [39:0]     glyph_r;
  logic [2:0]      col_cnt_r;
  res_t            res_r;
  res_t            out_r;
  logic            out_tvalid_r;

  logic [1:0]      in_kind;
  logic            in_start;
  logic [7:0]      in_col;
  logic [7:0]      in_page;
  logic [7:0]      in_char;
  logic            in_fire;
  logic            out_load;
  logic            ld_ok;
  logic [CCW-1:0]  col_eff;
  logic [PW-1:0]   page_eff;
  logic            act_eff;
  logic            fits;
  logic [AW-1:0]   base_addr;

  logic            st_we;
  logic [AW-1:0]   st_waddr;
  logic [7:0]      st_wdata;
  logic [AW-1:0]   st_raddr;
  logic [7:0]      st_rdata;

  res_t            ref_res;

  assign in_kind  = in_tuser[1:0];
  assign in_start = in_tuser[2];
  assign in_col   = in_tdata[7:0];
  assign in_page  = in_tdata[15:8];
  assign in_char  = in_tdata[23:16];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_RESULT) && (!out_tvalid_r || out_tready);

  assign ld_ok    = ({1'b0, in_page} < 9'(DISPLAY_PAGES)) && ({1'b0, in_col} < 9'(DISPLAY_WIDTH));
  assign col_eff  = (in_start && ld_ok) ? CCW'(in_col) : cursor_col_r;
  assign page_eff = (in_start && ld_ok) ? PW'(in_page) : cursor_page_r;
  assign act_eff  = in_start ? ld_ok : active_r;
  assign fits     = ({1'b0, col_eff} + (CCW+1)'(6)) <= (CCW+1)'(DISPLAY_WIDTH);
  assign base_addr = AW'(page_eff) * AW'(DISPLAY_WIDTH) + AW'(col_eff);

  assign st_we    = (state_r == ST_SWEEP) || (state_r == ST_DRAW);
  assign st_waddr = (state_r == ST_SWEEP) ? clr_addr_r : wr_addr_r;
  assign st_wdata = (state_r == ST_SWEEP) ? 8'h00 : glyph_r[39:32];
  assign st_raddr = AW'(ref_page_r) * AW'(DISPLAY_WIDTH) + AW'(ref_pos_r) - AW'(5);

  oledfb_store #(
    .DEPTH(STORE_SIZE),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  always_comb begin
    ref_res       = '0;
    ref_res.valid = 1'b1;
    priority if (ref_pos_r == POSW'(0)) begin
      ref_res.data   = CMD_CTRL;
      ref_res.tstart = 1'b1;
    end else if (ref_pos_r == POSW'(1)) begin
      ref_res.data = CMD_PAGE_BASE | 8'(ref_page_r);
    end else if (ref_pos_r == POSW'(2)) begin
      ref_res.data = CMD_COL_LOW;
    end else if (ref_pos_r == POSW'(3)) begin
      ref_res.data = CMD_COL_HIGH;
      ref_res.tend = 1'b1;
    end else if (ref_pos_r == POSW'(4)) begin
      ref_res.data   = DATA_CTRL;
      ref_res.tstart = 1'b1;
    end else begin
      ref_res.data = st_rdata;
      if (ref_pos_r == POSW'(DISPLAY_WIDTH + 4)) begin
        ref_res.tend = 1'b1;
        ref_res.done = (ref_page_r == PW'(DISPLAY_PAGES - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP;
      clr_addr_r    <= '0;
      sweep_reply_r <= 1'b0;
      cursor_col_r  <= '0;
      cursor_page_r <= '0;
      active_r      <= 1'b0;
      ref_page_r    <= '0;
      ref_pos_r     <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_SWEEP: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(STORE_SIZE - 1)) begin
            state_r <= sweep_reply_r ? ST_RESULT : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_kind)
              KIND_CLEAR: begin
                res_r         <= '0;
                clr_addr_r    <= '0;
                sweep_reply_r <= 1'b1;
                state_r       <= ST_SWEEP;
              end
              KIND_CHAR: begin
                cursor_page_r <= page_eff;
                if (in_char != CHAR_NUL && act_eff && fits) begin
                  cursor_col_r <= col_eff + CCW'(6);
                  active_r     <= 1'b1;
                  wr_addr_r    <= base_addr;
                  glyph_r      <= glyph_bits(in_char);
                  col_cnt_r    <= '0;
                  res_r        <= RES_DRAWN;
                  state_r      <= ST_DRAW;
                end else begin
                  cursor_col_r <= col_eff;
                  active_r     <= act_eff && (in_char != CHAR_NUL);
                  res_r        <= '0;
                  state_r      <= ST_RESULT;
                end
              end
              KIND_REFRESH: begin
                state_r <= ST_FETCH;
              end
              default: begin
                res_r   <= '0;
                state_r <= ST_RESULT;
              end
            endcase
          end
        end
        ST_DRAW: begin
          col_cnt_r <= col_cnt_r + 3'd1;
          wr_addr_r <= wr_addr_r + AW'(1);
          glyph_r   <= glyph_r << 8;
          if (col_cnt_r == 3'd5) begin
            state_r <= ST_RESULT;
          end
        end
        ST_FETCH: begin
          res_r <= ref_res;
          if (ref_pos_r == POSW'(DISPLAY_WIDTH + 4)) begin
            ref_pos_r  <= '0;
            ref_page_r <= (ref_page_r == PW'(DISPLAY_PAGES - 1)) ? '0 : ref_page_r + PW'(1);
          end else begin
            ref_pos_r <= ref_pos_r + POSW'(1);
          end
          state_r <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_load) begin
            out_r         <= res_r;
            sweep_reply_r <= 1'b0;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_r.data, out_r.valid};
  assign out_tuser  = {out_r.drawn, out_r.done, out_r.tstart};
  assign out_tlast  = out_r.tend;

endmodule

// ----- src/oledfb_store.sv -----
module oledfb_store #(
  parameter int DEPTH = oledfb_pkg::DISPLAY_WIDTH_DEF * oledfb_pkg::DISPLAY_PAGES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- tb/sv/oled_text_framebuffer_checker.sv -----
`timescale 1ns / 1ps
module oled_text_framebuffer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // column[7:0], page[15:8], character[23:16]
  input  logic [2:0]  in_tuser,   // kind[1:0], text_start[2]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // out_valid[0], out_byte[8:1], zero fill[15:9]
  input  logic [2:0]  out_tuser,  // transaction_start[0], frame_done[1], char_drawn[2]
  input  logic        out_tlast,  // transaction_end
  output int          errors,
  output int          pending
);

  import oledfb_pkg::*;

  localparam int WIDTH    = DISPLAY_WIDTH_DEF;
  localparam int PAGES    = DISPLAY_PAGES_DEF;
  localparam int PAGE_LEN = WIDTH + 5;
  localparam int FB_AW    = $clog2(WIDTH * PAGES);

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       xfer_start;
    logic       xfer_end;
    logic       frame_done;
    logic       char_drawn;
  } fb_result_t;

  localparam logic [39:0] LETTER_FONT [26] = '{
    40'h7C1211127C, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
    40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
    40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
    40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
    40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
    40'h0708700807, 40'h6151494543
  };

  localparam logic [39:0] DIGIT_FONT [10] = '{
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E
  };

  logic [7:0] shadow_fb [WIDTH*PAGES];
  int         cursor_col;
  int         cursor_pg;
  logic       text_open;
  int         refresh_pg;
  int         refresh_pos;
  int         err_count;
  fb_result_t result_q [$];

  // leftmost glyph column in the top byte
  function automatic logic [39:0] font_glyph(input logic [7:0] ch);
    if (ch >= 8'h41 && ch <= 8'h5A) return LETTER_FONT[5'(ch - 8'h41)];
    if (ch >= 8'h30 && ch <= 8'h39) return DIGIT_FONT[4'(ch - 8'h30)];
    case (ch)
      8'h3A:   return 40'h0036360000;
      8'h21:   return 40'h00083E0800;
      8'h25:   return 40'h0064186400;
      8'h2E:   return 40'h0040600000;
      default: return 40'h0;
    endcase
  endfunction

  function automatic fb_result_t predict_item(input logic [1:0] kind, input logic text_start,
                                              input logic [7:0] col, input logic [7:0] pg,
                                              input logic [7:0] ch);
    fb_result_t r;
    logic [39:0] g;
    int base;
    r = '0;
    case (kind)
      KIND_CLEAR: begin
        foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      end
      KIND_CHAR: begin
        if (text_start) begin
          if (pg < PAGES && col < WIDTH) begin
            cursor_col = col;
            cursor_pg  = pg;
            text_open  = 1'b1;
          end else begin
            text_open = 1'b0;
          end
        end
        if (ch == CHAR_NUL) begin
          text_open = 1'b0;
        end else if (text_open && cursor_col + 6 <= WIDTH) begin
          g    = font_glyph(ch);
          base = cursor_pg * WIDTH + cursor_col;
          for (int x = 0; x < 5; x++) shadow_fb[FB_AW'(base + x)] = g[39 - 8*x -: 8];
          shadow_fb[FB_AW'(base + 5)] = 8'h00;
          cursor_col += 6;
          r.char_drawn = 1'b1;
        end
      end
      KIND_REFRESH: begin
        r.valid = 1'b1;
        case (refresh_pos)
          0: begin
            r.data_byte  = CMD_CTRL;
            r.xfer_start = 1'b1;
          end
          1: r.data_byte = CMD_PAGE_BASE | 8'(refresh_pg);
          2: r.data_byte = CMD_COL_LOW;
          3: begin
            r.data_byte = CMD_COL_HIGH;
            r.xfer_end  = 1'b1;
          end
          4: begin
            r.data_byte  = DATA_CTRL;
            r.xfer_start = 1'b1;
          end
          default: begin
            r.data_byte = shadow_fb[FB_AW'(refresh_pg * WIDTH + refresh_pos - 5)];
            if (refresh_pos == PAGE_LEN - 1) begin
              r.xfer_end   = 1'b1;
              r.frame_done = (refresh_pg == PAGES - 1);
            end
          end
        endcase
        refresh_pos++;
        if (refresh_pos == PAGE_LEN) begin
          refresh_pos = 0;
          refresh_pg  = (refresh_pg + 1) % PAGES;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string field, input int want_v, input int got_v);
    err_count++;
    $display("%0t: %s expected %0h actual %0h", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    fb_result_t want;
    if (!rst_n) begin
      foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      cursor_col  = 0;
      cursor_pg   = 0;
      text_open   = 1'b0;
      refresh_pg  = 0;
      refresh_pos = 0;
      result_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected transaction expected none actual %h/%h/%b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          want = result_q.pop_front();
          if (out_tdata[0] !== want.valid)
            note_mismatch("out_valid", want.valid, out_tdata[0]);
          if (out_tdata[8:1] !== want.data_byte)
            note_mismatch("out_byte", want.data_byte, out_tdata[8:1]);
          if (out_tdata[15:9] !== 7'h00)
            note_mismatch("zero fill", 0, out_tdata[15:9]);
          if (out_tuser[0] !== want.xfer_start)
            note_mismatch("transaction_start", want.xfer_start, out_tuser[0]);
          if (out_tuser[1] !== want.frame_done)
            note_mismatch("frame_done", want.frame_done, out_tuser[1]);
          if (out_tuser[2] !== want.char_drawn)
            note_mismatch("char_drawn", want.char_drawn, out_tuser[2]);
          if (out_tlast !== want.xfer_end)
            note_mismatch("transaction_end", want.xfer_end, out_tlast);
        end
      end
      if (in_tvalid && in_tready)
        result_q.push_back(predict_item(in_tuser[1:0], in_tuser[2], in_tdata[7:0],
                                        in_tdata[15:8], in_tdata[23:16]));
    end
    errors  <= err_count;
    pending <= result_q.size();
  end

endmodule

// ----- tb/sv/tb_oled_text_framebuffer.sv -----
`timescale 1ns / 1ps
module tb_oled_text_framebuffer;
  import oledfb_pkg::*;

  localparam int         ITEM_TARGET = 1877;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // column[7:0], page[15:8], character[23:16]
  logic [2:0]  in_tuser;   // kind[1:0], text_start[2]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // out_valid[0], out_byte[8:1], zero fill[15:9]
  logic [2:0]  out_tuser;  // transaction_start[0], frame_done[1], char_drawn[2]
  logic        out_tlast;  // transaction_end

  int    errors;
  int    pending;
  int    items_sent;
  bit    no_idle;
  string font_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 :!%.";

  oled_text_framebuffer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  oled_text_framebuffer_checker fb_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input logic [1:0] kind, input logic text_start,
                           input logic [7:0] col, input logic [7:0] pg, input logic [7:0] ch);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {text_start, kind};
    in_tdata  <= {ch, pg, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) < 7) return font_chars[$urandom_range(0, font_chars.len() - 1)];
    return 8'($urandom_range(1, 255));
  endfunction

  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    int n;
    int act;
    logic [7:0] col;
    logic [7:0] pg;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    items_sent = 0;
    no_idle    = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    repeat (5) send_item(KIND_REFRESH, 1'b0, 8'h00, 8'h00, 8'h00);
    send_item(KIND_CHAR, 1'b1, 8'd0, 8'd0, "A");
    send_item(KIND_CHAR, 1'b0, 8'hFF, 8'hFF, "Z");
    send_item(KIND_CHAR, 1'b0, 8'h00, 8'h00, "0");
    send_item(KIND_CHAR, 1'b0, 8'h00, 8'h00, "9");
    send_item(KIND_CHAR, 1'b0, 8'h00, 8'h00, " ");
    send_item(KIND_CHAR, 1'b0, 8'h00, 8'h00, ":");
    send_item(KIND_CHAR, 1'b0, 8'h00, 8'h00, "!");
    send_item(KIND_CHAR, 1'b0, 8'h00, 8'h00, "%");
    send_item(KIND_CHAR, 1'b0, 8'h00, 8'h00, ".");
    send_item(KIND_CHAR, 1'b0, 8'h00, 8'h00, 8'h7F);
    send_item(KIND_CHAR, 1'b0, 8'h00, 8'h00, CHAR_NUL);
    send_item(KIND_CHAR, 1'b0, 8'h00, 8'h00, "B");
    send_item(KIND_CHAR, 1'b1, 8'd0, 8'd8, "A");
    send_item(KIND_CHAR, 1'b1, 8'd128, 8'd0, "B");
    send_item(KIND_CHAR, 1'b1, 8'd255, 8'd255, "C");
    send_item(KIND_CHAR, 1'b1, 8'd5, 8'd3, CHAR_NUL);
    send_item(KIND_CHAR, 1'b1, 8'd122, 8'd7, "X");
    send_item(KIND_CHAR, 1'b0, 8'h00, 8'h00, "Y");
    send_item(KIND_CHAR, 1'b1, 8'd123, 8'd7, "Q");
    send_item(KIND_NONE, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_item(KIND_CLEAR, 1'b0, 8'h00, 8'h00, 8'h00);
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 8) no_idle = !no_idle;
      act = $urandom_range(0, 99);
      if (act < 45) begin
        n = $urandom_range(1, 60);
        repeat (n) send_item(KIND_REFRESH, 1'($urandom_range(0, 1)), 8'($urandom),
                             8'($urandom), 8'($urandom));
      end else if (act < 80) begin
        if ($urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 1) == 1) begin
            col = 8'($urandom_range(0, 255));
            pg  = 8'($urandom_range(8, 255));
          end else begin
            col = 8'($urandom_range(128, 255));
            pg  = 8'($urandom_range(0, 255));
          end
        end else begin
          col = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(100, 127))
                                            : 8'($urandom_range(0, 127));
          pg  = 8'($urandom_range(0, 7));
        end
        send_item(KIND_CHAR, 1'b1, col, pg,
                  ($urandom_range(0, 15) == 0) ? CHAR_NUL : pick_char());
        n = $urandom_range(0, 24);
        repeat (n) send_item(KIND_CHAR, 1'b0, 8'($urandom), 8'($urandom), pick_char());
        if ($urandom_range(0, 3) != 0)
          send_item(KIND_CHAR, 1'b0, 8'($urandom), 8'($urandom), CHAR_NUL);
      end else if (act < 95) begin
        send_item(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1)), 8'($urandom),
                  8'($urandom), 8'($urandom));
      end else if (act < 97) begin
        send_item(KIND_CLEAR, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                  8'($urandom));
      end else begin
        drain_results();
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/oledfb_pkg.sv
src/oledfb_store.sv
src/oled_text_framebuffer.sv
tb/sv/oled_text_framebuffer_checker.sv
tb/sv/tb_oled_text_framebuffer.sv
